// File: design/fall_detector_window_range_macros.svh
// Assertion macros shared by the checker of the fall detector.
// Depends on nothing; included by the checker file only.
`ifndef FALL_DETECTOR_WINDOW_RANGE_MACROS_SVH
`define FALL_DETECTOR_WINDOW_RANGE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define FDWR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fall detector check failed");

// Next-cycle implication, quiet during reset.
`define FDWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fall detector check failed");

`endif

// File: design/fdwr_pkg.sv
// Types and constants of the fall detector window range block.
// Depends on nothing; imported by every module of the block but fdwr_ram.
`default_nettype none
package fdwr_pkg;

  typedef struct packed {
    logic [31:0]        timestamp_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_t;

  typedef struct packed {
    logic        fall_state;
    logic [15:0] accel_span;
    logic [15:0] gyro_span;
    logic [6:0]  samples_in_window;
    logic        tilt_beyond;
  } out_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] amag;
    logic [15:0] gmag;
  } entry_t;

  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_COS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_COS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_MS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 3'd6;

  localparam logic [15:0]        RST_ACCEL_THR = 16'd2297;
  localparam logic [15:0]        RST_GYRO_THR  = 16'd786;
  localparam logic signed [16:0] RST_UPPER_COS = 17'sd16384;
  localparam logic signed [16:0] RST_LOWER_COS = 17'sd32768;
  localparam logic [15:0]        RST_LATCH_MS  = 16'd3000;
  localparam logic [15:0]        RST_WINDOW_MS = 16'd1000;
  localparam logic [15:0]        RST_GRAVITY   = 16'd4096;

endpackage
`default_nettype wire

// File: design/fall_detector_window_range.sv
// Fall detector over a time window of accel and gyro magnitudes.
// Input channel in_valid/in_ready carries one timestamped sample (in_t); the
// output channel out_valid/out_ready returns one result (out_t) per sample.
// The configuration port writes one register per cycle while cfg_write is
// high; write only while the block is idle.
// One sample at a time: in_ready is high only when the sequencer is idle.
// From accept to out_valid the sequencer steps through each magnitude on the
// shared magnitude unit (start, squaring of each axis, 16 root steps and a
// capture), the cosine divider (start, 31 quotient steps and a capture), one
// window write, an age check of the oldest entry that is repeated for each
// pruned entry, a sweep of the live entries through the window RAM read port
// and the load of the output register.
// Reset returns the registers to their defaults, empties the window (head and
// fill cleared; RAM contents need no clearing) and releases the fall latch.
// A finished result waits in the output register; a stalled receiver holds
// the sequencer in its last step, and a new sample is accepted as soon as the
// previous result has been moved to the output register.
`default_nettype none
module fall_detector_window_range #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire fdwr_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output fdwr_pkg::out_t                      out_data,
  input  wire logic                           cfg_write,
  input  wire logic [fdwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fdwr_pkg::CFG_W-1:0]     cfg_data
);
  import fdwr_pkg::*;

  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int CW = (FW > 7) ? FW : 7;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAGA = 4'd1;
  localparam logic [3:0] S_MAGG = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_INS  = 4'd4;
  localparam logic [3:0] S_PRD  = 4'd5;
  localparam logic [3:0] S_PCHK = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  // configuration
  logic [15:0]        accel_thr, gyro_thr, latch_ms, window_ms, gravity;
  logic signed [16:0] upper_cos, lower_cos;

  logic [3:0]  state;
  in_t         smp;
  logic [15:0] amag, gmag;
  logic signed [16:0] cos_r;
  logic [IW-1:0] head, ptr, head_inc, ptr_inc, slot, raddr;
  logic [FW-1:0] fill, issued;
  logic [FW:0]   slot_sum;
  logic          rd_pend, first;
  logic [15:0]   amin, amax, gmin, gmax;
  logic          fall_latched, fall_latched_next;
  logic [31:0]   latch_start, latch_start_next;

  logic        mag_go, mag_done, div_go, div_done;
  logic signed [15:0] mx, my, mz;
  logic [15:0] mag, denom;
  logic signed [16:0] div_cos;

  entry_t      wentry, rentry;
  logic        we;
  logic [31:0] age;
  logic [15:0] arange, grange;
  logic        tilt, out_free;
  logic [CW-1:0] fill_ext;

  always_comb begin
    if (state == S_MAGA) begin
      mx = smp.accel_x;
      my = smp.accel_y;
      mz = smp.accel_z;
    end else begin
      mx = smp.gyro_x;
      my = smp.gyro_y;
      mz = smp.gyro_z;
    end
    denom    = (amag != 16'd0) ? amag : gravity;
    head_inc = (head == IW'(WINDOW_DEPTH - 1)) ? '0 : head + IW'(1);
    ptr_inc  = (ptr == IW'(WINDOW_DEPTH - 1)) ? '0 : ptr + IW'(1);
    slot_sum = (FW + 1)'(head) + (FW + 1)'(fill);
    slot     = (slot_sum >= (FW + 1)'(WINDOW_DEPTH)) ?
               IW'(slot_sum - (FW + 1)'(WINDOW_DEPTH)) : IW'(slot_sum);
    raddr    = (state == S_SCAN) ? ptr : head;
    we       = (state == S_INS);
    wentry   = '{time_ms: smp.timestamp_ms, amag: amag, gmag: gmag};
    age      = smp.timestamp_ms - rentry.time_ms;
    arange   = (fill != '0) ? amax - amin : 16'd0;
    grange   = (fill != '0) ? gmax - gmin : 16'd0;
    tilt     = (cos_r <= upper_cos) || (cos_r >= lower_cos);
    out_free = !out_valid || out_ready;
    fill_ext = CW'(fill);
    // two-state latch: detect while monitoring, release after the latch time
    fall_latched_next = fall_latched;
    latch_start_next  = latch_start;
    if (!fall_latched) begin
      if (fill != '0 && arange >= accel_thr && grange >= gyro_thr && tilt) begin
        fall_latched_next = 1'b1;
        latch_start_next  = smp.timestamp_ms;
      end
    end else if ((smp.timestamp_ms - latch_start) > {16'd0, latch_ms}) begin
      fall_latched_next = 1'b0;
      latch_start_next  = smp.timestamp_ms;
    end
  end

  assign in_ready = (state == S_IDLE);

  fdwr_mag u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (mag_go),
    .x     (mx),
    .y     (my),
    .z     (mz),
    .done  (mag_done),
    .mag   (mag)
  );

  fdwr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (smp.accel_z),
    .den   (denom),
    .done  (div_done),
    .cos_q (div_cos)
  );

  fdwr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rentry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_thr <= RST_ACCEL_THR;
      gyro_thr  <= RST_GYRO_THR;
      upper_cos <= RST_UPPER_COS;
      lower_cos <= RST_LOWER_COS;
      latch_ms  <= RST_LATCH_MS;
      window_ms <= RST_WINDOW_MS;
      gravity   <= RST_GRAVITY;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACCEL_THR: accel_thr <= cfg_data[15:0];
        REG_GYRO_THR:  gyro_thr  <= cfg_data[15:0];
        REG_UPPER_COS: upper_cos <= $signed(cfg_data);
        REG_LOWER_COS: lower_cos <= $signed(cfg_data);
        REG_LATCH_MS:  latch_ms  <= cfg_data[15:0];
        REG_WINDOW_MS: window_ms <= cfg_data[15:0];
        REG_GRAVITY:   gravity   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      fill         <= '0;
      fall_latched <= 1'b0;
      latch_start  <= '0;
      out_valid    <= 1'b0;
      mag_go       <= 1'b0;
      div_go       <= 1'b0;
      rd_pend      <= 1'b0;
      issued       <= '0;
      first        <= 1'b0;
    end else begin
      mag_go    <= ((state == S_IDLE) && in_valid) || ((state == S_MAGA) && mag_done);
      div_go    <= (state == S_MAGG) && mag_done;
      // hold the result until the receiver takes it
      out_valid <= ((state == S_FIN) && out_free) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp   <= in_data;
            state <= S_MAGA;
          end
        end
        S_MAGA: begin
          if (mag_done) begin
            amag  <= mag;
            state <= S_MAGG;
          end
        end
        S_MAGG: begin
          if (mag_done) begin
            gmag  <= mag;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cos_r <= div_cos;
            state <= S_INS;
          end
        end
        S_INS: begin
          // overwrite the oldest entry when the ring is full
          if (fill < FW'(WINDOW_DEPTH)) begin
            fill <= fill + FW'(1);
          end else begin
            head <= head_inc;
          end
          state <= S_PRD;
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (fill != '0 && age > {16'd0, window_ms}) begin
            head  <= head_inc;
            fill  <= fill - FW'(1);
            state <= S_PRD;
          end else begin
            ptr     <= head;
            issued  <= '0;
            rd_pend <= 1'b0;
            first   <= 1'b1;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issued != fill) begin
            ptr     <= ptr_inc;
            issued  <= issued + FW'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            first <= 1'b0;
            if (first || rentry.amag < amin) amin <= rentry.amag;
            if (first || rentry.amag > amax) amax <= rentry.amag;
            if (first || rentry.gmag < gmin) gmin <= rentry.gmag;
            if (first || rentry.gmag > gmax) gmax <= rentry.gmag;
          end
          if (issued == fill && !rd_pend) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            fall_latched               <= fall_latched_next;
            latch_start                <= latch_start_next;
            out_data.fall_state        <= fall_latched_next;
            out_data.accel_span        <= arange;
            out_data.gyro_span         <= grange;
            out_data.samples_in_window <= fill_ext[6:0];
            out_data.tilt_beyond       <= tilt;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/fdwr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module fdwr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/fdwr_mag.sv
// Vector magnitude: sum of squares with one shared multiplier, then a
// bit-serial integer square root. Depends on fdwr_pkg.
`default_nettype none
module fdwr_mag (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic signed [15:0] z,
  output logic                    done,
  output logic [15:0]             mag
);
  import fdwr_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_ROOT = 2'd2;

  logic [1:0]         ph;
  logic [3:0]         cnt;
  logic signed [15:0] xr, yr, zr, op;
  logic signed [31:0] sq;
  logic [31:0]        acc, v, res, bitm, t;

  always_comb begin
    op = (cnt == 4'd0) ? xr : ((cnt == 4'd1) ? yr : zr);
    sq = op * op;
    t  = res + bitm;
  end

  assign mag = res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= P_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (ph == P_ROOT) && (cnt == 4'd15);
      unique case (ph)
        P_IDLE: begin
          if (start) begin
            xr  <= x;
            yr  <= y;
            zr  <= z;
            acc <= '0;
            cnt <= '0;
            ph  <= P_MUL;
          end
        end
        P_MUL: begin
          if (cnt == 4'd2) begin
            v    <= acc + $unsigned(sq);
            res  <= '0;
            bitm <= 32'h4000_0000;
            cnt  <= '0;
            ph   <= P_ROOT;
          end else begin
            acc <= acc + $unsigned(sq);
            cnt <= cnt + 4'd1;
          end
        end
        P_ROOT: begin
          // one result bit per cycle
          if (v >= t) begin
            v   <= v - t;
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
          if (cnt == 4'd15) begin
            ph <= P_IDLE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        default: ph <= P_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/fdwr_div.sv
// Tilt cosine: restoring division of accel_z * 32768 by the magnitude,
// one quotient bit per cycle, clamped to Q1.15. Depends on fdwr_pkg.
`default_nettype none
module fdwr_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] num,
  input  wire logic [15:0]        den,
  output logic                    done,
  output logic signed [16:0]      cos_q
);
  import fdwr_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RUN  = 2'd1;

  logic [1:0]  ph;
  logic [4:0]  cnt;
  logic [30:0] n, q;
  logic [15:0] d, rem, absn, qm;
  logic [16:0] sh, mag17;
  logic        neg;

  always_comb begin
    absn  = num[15] ? 16'(-num) : 16'(num);
    sh    = {rem, n[30]};
    qm    = (q > 31'd32768) ? 16'h8000 : q[15:0];
    mag17 = {1'b0, qm};
    if (d == 16'd0) begin
      cos_q = '0;
    end else if (neg) begin
      cos_q = -$signed(mag17);
    end else begin
      cos_q = $signed(mag17);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= P_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (ph == P_RUN) && (cnt == 5'd30);
      unique case (ph)
        P_IDLE: begin
          if (start) begin
            n   <= {absn, 15'b0};
            d   <= den;
            neg <= num[15];
            rem <= '0;
            q   <= '0;
            cnt <= '0;
            ph  <= P_RUN;
          end
        end
        P_RUN: begin
          if (sh >= {1'b0, d}) begin
            rem <= 16'(sh - {1'b0, d});
            q   <= {q[29:0], 1'b1};
          end else begin
            rem <= sh[15:0];
            q   <= {q[29:0], 1'b0};
          end
          n <= n << 1;
          if (cnt == 5'd30) begin
            ph <= P_IDLE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: ph <= P_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/fdwr_checker.sv
// Port-level checks of the fall detector, bound to the top level.
// Depends on fdwr_pkg and fall_detector_window_range_macros.svh.
`default_nettype none
`include "fall_detector_window_range_macros.svh"
module fdwr_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire fdwr_pkg::out_t out_data
);
  import fdwr_pkg::*;

  // one transaction in flight: ready drops right after an accept
  `FDWR_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  // the newest sample always survives pruning
  `FDWR_ASSERT_IMPLY(a_window_nonempty, clk, rst, out_valid, out_data.samples_in_window != 7'd0)
  `FDWR_ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid)
  `FDWR_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_data))
endmodule

bind fall_detector_window_range fdwr_checker u_fdwr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/fall_detector_window_range_test.sv
// Self-checking testbench of the fall detector window range block.
// Depends on fdwr_pkg and fall_detector_window_range; predicts each result.
`timescale 1ns / 1ps
module fall_detector_window_range_test;
  import fdwr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 105;

  typedef struct {
    in_t  sample;
    bit   known;
    out_t result;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  fall_detector_window_range DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state and register copies
  logic [15:0] m_accel_thr, m_gyro_thr, m_latch_ms, m_window_ms, m_gravity;
  logic signed [16:0] m_upper_cos, m_lower_cos;
  logic        m_latched;
  logic [31:0] m_latch_start;
  logic [31:0] m_time [DEPTH];
  logic [15:0] m_amag [DEPTH];
  logic [15:0] m_gmag [DEPTH];
  logic [5:0]  m_head;
  logic [6:0]  m_fill;

  out_t pending_results[$];
  int   errors = 0;
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   hold_req = 0;
  int   quiet_cycles = 0;
  row_t rows[$];

  function automatic logic [31:0] int_root(logic [31:0] v);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] vec_mag(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z);
    int xi, yi, zi;
    logic [31:0] s;
    xi = x; yi = y; zi = z;
    s = 32'(xi * xi) + 32'(yi * yi) + 32'(zi * zi);
    return 16'(int_root(s));
  endfunction

  function automatic out_t predict_result(in_t s);
    out_t o;
    logic [15:0] amag, gmag, amin, amax, gmin, gmax, arange, grange;
    logic [31:0] denom, age;
    logic [5:0] slot, k;
    longint c;
    bit tilt;
    amag = vec_mag(s.accel_x, s.accel_y, s.accel_z);
    gmag = vec_mag(s.gyro_x, s.gyro_y, s.gyro_z);
    denom = (amag != 0) ? {16'd0, amag} : {16'd0, m_gravity};
    c = 0;
    if (denom != 0) begin
      c = (longint'(s.accel_z) * 32768) / longint'(denom);
      if (c < -32768) c = -32768;
      if (c > 32768) c = 32768;
    end
    tilt = (c <= longint'(m_upper_cos)) || (c >= longint'(m_lower_cos));
    // insert, overwriting the oldest entry when full
    slot = m_head + m_fill[5:0];
    m_time[slot] = s.timestamp_ms;
    m_amag[slot] = amag;
    m_gmag[slot] = gmag;
    if (m_fill < DEPTH) m_fill = m_fill + 1;
    else m_head = m_head + 1;
    // drop entries older than the window
    while (m_fill > 0) begin
      age = s.timestamp_ms - m_time[m_head];
      if (age <= {16'd0, m_window_ms}) break;
      m_head = m_head + 1;
      m_fill = m_fill - 1;
    end
    arange = 0;
    grange = 0;
    if (m_fill > 0) begin
      amin = m_amag[m_head]; amax = amin;
      gmin = m_gmag[m_head]; gmax = gmin;
      for (int i = 1; i < m_fill; i++) begin
        k = m_head + 6'(i);
        if (m_amag[k] < amin) amin = m_amag[k];
        if (m_amag[k] > amax) amax = m_amag[k];
        if (m_gmag[k] < gmin) gmin = m_gmag[k];
        if (m_gmag[k] > gmax) gmax = m_gmag[k];
      end
      arange = amax - amin;
      grange = gmax - gmin;
    end
    if (!m_latched) begin
      if (m_fill > 0 && arange >= m_accel_thr && grange >= m_gyro_thr && tilt) begin
        m_latched = 1'b1;
        m_latch_start = s.timestamp_ms;
      end
    end else if (32'(s.timestamp_ms - m_latch_start) > {16'd0, m_latch_ms}) begin
      m_latched = 1'b0;
      m_latch_start = s.timestamp_ms;
    end
    o.fall_state = m_latched;
    o.accel_span = arange;
    o.gyro_span = grange;
    o.samples_in_window = m_fill;
    o.tilt_beyond = tilt;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.fall_state !== want.fall_state)
          report_mismatch("fall_state", out_data.fall_state, want.fall_state);
        if (out_data.accel_span !== want.accel_span)
          report_mismatch("accel_span", out_data.accel_span, want.accel_span);
        if (out_data.gyro_span !== want.gyro_span)
          report_mismatch("gyro_span", out_data.gyro_span, want.gyro_span);
        if (out_data.samples_in_window !== want.samples_in_window)
          report_mismatch("samples_in_window", out_data.samples_in_window,
                          want.samples_in_window);
        if (out_data.tilt_beyond !== want.tilt_beyond)
          report_mismatch("tilt_beyond", out_data.tilt_beyond, want.tilt_beyond);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    static int hold_left = 0;
    static int hold_seen = 0;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_sample(in_t s, bit known, out_t want);
    out_t predicted;
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    predicted = predict_result(s);
    pending_results.push_back(known ? want : predicted);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // called at a falling edge; leaves cfg_write high for the caller to drop
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    case (idx)
      REG_ACCEL_THR: m_accel_thr = 16'(value);
      REG_GYRO_THR:  m_gyro_thr = 16'(value);
      REG_UPPER_COS: m_upper_cos = 17'(value);
      REG_LOWER_COS: m_lower_cos = 17'(value);
      REG_LATCH_MS:  m_latch_ms = 16'(value);
      REG_WINDOW_MS: m_window_ms = 16'(value);
      REG_GRAVITY:   m_gravity = 16'(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic in_t mk(logic [31:0] t, int ax, int ay, int az, int gx, int gy, int gz);
    in_t s;
    s.timestamp_ms = t;
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
    s.gyro_x = 16'(gx); s.gyro_y = 16'(gy); s.gyro_z = 16'(gz);
    return s;
  endfunction

  function automatic void add_row(in_t s, bit known, out_t want);
    row_t r;
    r.sample = s; r.known = known; r.result = want;
    rows.push_back(r);
  endfunction

  function automatic int rand_axis();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom_range(0, 65535) - 32768;
    if (pick < 80) return $urandom_range(0, 1200) - 600;
    if (pick < 90) return $urandom_range(1) ? 32767 : -32768;
    return 0;
  endfunction

  function automatic int rand_cos();
    return $urandom_range(0, 65536) - 32768;
  endfunction

  initial begin
    in_t s;
    logic [31:0] ts;
    int pick;
    m_accel_thr = RST_ACCEL_THR; m_gyro_thr = RST_GYRO_THR;
    m_upper_cos = RST_UPPER_COS; m_lower_cos = RST_LOWER_COS;
    m_latch_ms = RST_LATCH_MS; m_window_ms = RST_WINDOW_MS; m_gravity = RST_GRAVITY;
    m_latched = 0; m_latch_start = 0; m_head = 0; m_fill = 0;

    // directed rows at reset defaults
    add_row(mk(0, 0, 0, 4096, 0, 0, 0), 1, '{1'b0, 16'd0, 16'd0, 7'd1, 1'b1});
    add_row(mk(10, 0, 0, 0, 0, 0, 0), 1, '{1'b0, 16'd4096, 16'd0, 7'd2, 1'b1});
    add_row(mk(20, -32768, -32768, -32768, 32767, 32767, 32767), 0, '0);
    add_row(mk(30, 32767, 32767, 32767, -32768, -32768, -32768), 0, '0);
    add_row(mk(40, 0, 0, -32768, 0, 0, 0), 0, '0);
    add_row(mk(50, 32767, 0, 0, 0, -32768, 0), 0, '0);
    add_row(mk(3100, 0, 0, 32767, 0, 0, 32767), 0, '0);
    add_row(mk(3100, 0, 0, 32767, 0, 0, 32767), 0, '0);
    add_row(mk(3200, 100, -200, 4000, 5, -5, 5), 0, '0);
    add_row(mk(32'hFFFF_FF00, 0, 0, 4096, 0, 0, 0), 0, '0);
    add_row(mk(32'h0000_0010, -32768, 32767, 0, -32768, 32767, 0), 0, '0);
    add_row(mk(32'h0000_0400, 0, 0, 0, 32767, 0, 0), 0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].result);
    in_valid <= 1'b0;
    ts = 32'h0000_0800;

    for (int p = 1; p <= N_PHASES; p++) begin
      wait (pending_results.size() == 0);
      @(negedge clk);
      if (p == 1) begin
        write_reg(REG_ACCEL_THR, 0); write_reg(REG_GYRO_THR, 0);
        write_reg(REG_UPPER_COS, -32768); write_reg(REG_LOWER_COS, -32768);
        write_reg(REG_LATCH_MS, 0); write_reg(REG_WINDOW_MS, 0);
        write_reg(REG_GRAVITY, 1);
      end else if (p == 2) begin
        write_reg(REG_ACCEL_THR, 65535); write_reg(REG_GYRO_THR, 65535);
        write_reg(REG_UPPER_COS, 32768); write_reg(REG_LOWER_COS, 32768);
        write_reg(REG_LATCH_MS, 65535); write_reg(REG_WINDOW_MS, 65535);
        write_reg(REG_GRAVITY, 65535);
      end else begin
        write_reg(REG_ACCEL_THR, $urandom_range(0, 9000));
        write_reg(REG_GYRO_THR, $urandom_range(0, 9000));
        write_reg(REG_UPPER_COS, rand_cos());
        write_reg(REG_LOWER_COS, rand_cos());
        write_reg(REG_LATCH_MS, $urandom_range(0, 400));
        write_reg(REG_WINDOW_MS, $urandom_range(0, 1500));
        write_reg(REG_GRAVITY, $urandom_range(1, 65535));
      end
      write_reg(REG_UNUSED, $urandom_range(0, 131071));
      cfg_write <= 1'b0;
      case (p % 4)
        0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
        1: begin snd_idle_pct = 87; rcv_stall_pct = 0; end
        2: begin snd_idle_pct = 0; rcv_stall_pct = 87; end
        default: begin snd_idle_pct = 12; rcv_stall_pct = 12; end
      endcase
      // stall the output while samples keep coming
      if (p == 4) hold_req++;
      @(negedge clk);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 5 && i == 50) begin
          in_valid <= 1'b0;
          wait (pending_results.size() == 0);
          @(negedge clk);
        end
        pick = $urandom_range(99);
        if (pick < 55) ts = ts + $urandom_range(0, 12);
        else if (pick < 70) ts = ts + $urandom_range(12, 60);
        else if (pick < 85) ;
        else if (pick < 95) ts = ts + $urandom_range(60, 4000);
        else if (pick < 98) ts = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else ts = $urandom();
        s = mk(ts, rand_axis(), rand_axis(), rand_axis(),
               rand_axis(), rand_axis(), rand_axis());
        send_sample(s, 0, '0);
      end
      in_valid <= 1'b0;
    end

    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
